/* rtl/core/hwb_pkg.sv */
`default_nettype none
package hwb_pkg;
	localparam int unsigned DefMaxRows = 256;
	localparam int unsigned DefMaxCols = 256;

	// register indexes
	localparam logic [2:0] REG_CX   = 3'd0;
	localparam logic [2:0] REG_CY   = 3'd1;
	localparam logic [2:0] REG_CZ   = 3'd2;
	localparam logic [2:0] REG_QUAT = 3'd3;
	localparam logic [2:0] REG_CS   = 3'd4;
	localparam logic [2:0] REG_ROWS = 3'd5;
	localparam logic [2:0] REG_COLS = 3'd6;

	// shared multiplier operand request
	typedef struct packed {
		logic signed [33:0] a;
		logic signed [33:0] b;
	} mul_req_t;

	// round half up by s bits (floor shift after adding half)
	function automatic logic signed [63:0] rshr64(input logic signed [63:0] v, input int s);
		logic signed [63:0] t;
		begin
			t = v + (64'sd1 <<< (s - 1));
			rshr64 = t >>> s;
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		begin
			if (v > 64'sh000000007FFFFFFF) sat32 = 32'sh7FFFFFFF;
			else if (v < -64'sh0000000080000000) sat32 = 32'sh80000000;
			else sat32 = v[31:0];
		end
	endfunction
endpackage
`default_nettype wire

/* rtl/core/hwb_mul.sv */
`default_nettype none
// shared signed multiplier with registered product
module hwb_mul
	import hwb_pkg::*;
(
	input  wire logic              clk,
	input  wire mul_req_t          req,
	output logic signed [67:0]     prod_q
);
	// two partial products, 34x17 each, summed into a second register
	logic signed [50:0] lo_q;
	logic signed [50:0] hi_q;

	always_ff @(posedge clk) begin
		lo_q <= 51'(req.a * $signed({1'b0, req.b[16:0]}));
		hi_q <= 51'(req.a * $signed(req.b[33:17]));
		prod_q <= 68'(lo_q) + (68'(hi_q) <<< 17);
	end
endmodule
`default_nettype wire

/* rtl/core/hwb_regs.sv */
`default_nettype none
// configuration registers on the apb-style port
module hwb_regs
	import hwb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [5:0]         paddr,
	input  wire logic [63:0]        pwdata,
	output logic [63:0]             prdata,
	output logic signed [31:0]      cx_q,
	output logic signed [31:0]      cy_q,
	output logic signed [31:0]      cz_q,
	output logic [63:0]             quat_q,
	output logic [30:0]             cs_q,
	output logic [8:0]              rows_q,
	output logic [8:0]              cols_q
);
	logic [2:0] idx;
	assign idx = paddr[5:3];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			quat_q <= 64'h4000_0000_0000_0000;
			cs_q <= 31'd65536;
			rows_q <= '0; cols_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_CX:   cx_q <= pwdata[31:0];
				REG_CY:   cy_q <= pwdata[31:0];
				REG_CZ:   cz_q <= pwdata[31:0];
				REG_QUAT: quat_q <= pwdata;
				REG_CS:   cs_q <= pwdata[30:0];
				REG_ROWS: rows_q <= pwdata[8:0];
				REG_COLS: cols_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_CX:   prdata = {{32{cx_q[31]}}, cx_q};
			REG_CY:   prdata = {{32{cy_q[31]}}, cy_q};
			REG_CZ:   prdata = {{32{cz_q[31]}}, cz_q};
			REG_QUAT: prdata = quat_q;
			REG_CS:   prdata = {33'd0, cs_q};
			REG_ROWS: prdata = {55'd0, rows_q};
			REG_COLS: prdata = {55'd0, cols_q};
			default:  prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/core/heightfield_world_bounds.sv */
`default_nettype none
// the bounds word is registered in the output state, reached from a closing sample
// through the multiply and fold states, and from a closing word with no sample directly
// no word is taken while a sample is in the multiply or fold states or a bounds word
// waits for the result side; other words are taken every cycle while none waits
// the sequencer steps one shared multiplier through 10 quaternion, 2 spacing, 9 matrix products
// reset clears grid position, flags, sequencer and output valid; registers take defaults
module heightfield_world_bounds
	import hwb_pkg::*;
#(
	parameter int unsigned MAX_ROWS = DefMaxRows,
	parameter int unsigned MAX_COLS = DefMaxCols
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: height[31:0]
	input  wire logic [31:0] s_tdata,
	// tuser: has_sample[0]
	input  wire logic        s_tuser,
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: min_x, min_y, min_z, max_x, max_y, max_z from bit 0 upward
	output logic [191:0]     m_tdata,
	// tuser: empty_grid[0], count_mismatch[1]
	output logic [1:0]       m_tuser
);
	localparam int PW = $clog2(MAX_ROWS > MAX_COLS ? MAX_ROWS + 1 : MAX_COLS + 1) + 1;

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_FOLD = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;

	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [63:0] quat_q;
	logic [30:0] cs_q;
	logic [8:0] rows_q, cols_q;

	assign pready = 1'b1;

	hwb_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.cx_q, .cy_q, .cz_q, .quat_q, .cs_q, .rows_q, .cols_q
	);

	// effective grid size
	logic [PW-1:0] erows, ecols;
	always_comb begin
		erows = (32'(rows_q) > MAX_ROWS) ? PW'(MAX_ROWS) : PW'(rows_q);
		ecols = (32'(cols_q) > MAX_COLS) ? PW'(MAX_COLS) : PW'(cols_q);
	end

	logic [2:0] st_q;
	logic [5:0] step_q;
	logic [PW-1:0] row_q, col_q;
	logic extra_q, seen_q, close_q;
	logic signed [31:0] h_q;
	logic signed [63:0] prod_sq_q [0:9];
	logic signed [31:0] loc_q [0:2];
	logic signed [19:0] m_q [0:8];
	logic signed [63:0] acc_q;
	logic signed [31:0] wv_q [0:2];
	logic signed [31:0] lo_q [0:2];
	logic signed [31:0] hi_q [0:2];

	mul_req_t req;
	logic signed [67:0] prod_q;
	hwb_mul u_mul (.clk, .req, .prod_q);

	// quaternion components
	logic signed [15:0] qw, qx, qy, qz;
	assign qw = quat_q[63:48];
	assign qx = quat_q[47:32];
	assign qy = quat_q[31:16];
	assign qz = quat_q[15:0];

	// step plan: 0..9 quaternion products, 10..11 spacing, 14..22 matrix times local
	// product arrives through the partial-product registers and then the sum register
	logic [4:0] issue;
	assign issue = step_q[4:0];
	logic signed [PW+1:0] offc, offr;
	always_comb begin
		offc = $signed({1'b0, col_q, 1'b0}) - $signed({2'b0, ecols}) + (PW+2)'(1);
		offr = $signed({1'b0, row_q, 1'b0}) - $signed({2'b0, erows}) + (PW+2)'(1);
		req.a = '0;
		req.b = '0;
		case (issue)
			5'd0: begin req.a = 34'(qw); req.b = 34'(qw); end
			5'd1: begin req.a = 34'(qx); req.b = 34'(qx); end
			5'd2: begin req.a = 34'(qy); req.b = 34'(qy); end
			5'd3: begin req.a = 34'(qz); req.b = 34'(qz); end
			5'd4: begin req.a = 34'(qx); req.b = 34'(qy); end
			5'd5: begin req.a = 34'(qx); req.b = 34'(qz); end
			5'd6: begin req.a = 34'(qy); req.b = 34'(qz); end
			5'd7: begin req.a = 34'(qw); req.b = 34'(qx); end
			5'd8: begin req.a = 34'(qw); req.b = 34'(qy); end
			5'd9: begin req.a = 34'(qw); req.b = 34'(qz); end
			5'd10: begin req.a = 34'(offc); req.b = $signed({3'b0, cs_q}); end
			5'd11: begin req.a = 34'(offr); req.b = $signed({3'b0, cs_q}); end
			5'd14: begin req.a = 34'(m_q[0]); req.b = 34'(loc_q[0]); end
			5'd15: begin req.a = 34'(m_q[1]); req.b = 34'(loc_q[1]); end
			5'd16: begin req.a = 34'(m_q[2]); req.b = 34'(loc_q[2]); end
			5'd17: begin req.a = 34'(m_q[3]); req.b = 34'(loc_q[0]); end
			5'd18: begin req.a = 34'(m_q[4]); req.b = 34'(loc_q[1]); end
			5'd19: begin req.a = 34'(m_q[5]); req.b = 34'(loc_q[2]); end
			5'd20: begin req.a = 34'(m_q[6]); req.b = 34'(loc_q[0]); end
			5'd21: begin req.a = 34'(m_q[7]); req.b = 34'(loc_q[1]); end
			5'd22: begin req.a = 34'(m_q[8]); req.b = 34'(loc_q[2]); end
			default: ;
		endcase
	end

	// matrix entries from squared and cross products, rounded to q14
	logic signed [63:0] one28;
	assign one28 = 64'sd1 <<< 28;
	function automatic logic signed [19:0] r14(input logic signed [63:0] v);
		logic signed [63:0] t;
		begin
			t = rshr64(v, 14);
			r14 = t[19:0];
		end
	endfunction

	logic accept_in;
	assign s_tready = (st_q == ST_IDLE) && !m_tvalid;
	assign accept_in = s_tvalid && s_tready;
	logic in_grid;
	assign in_grid = (row_q < erows) && (col_q < ecols);

	logic [3:0] arr;
	assign arr = 4'(step_q - 6'd2);

	logic signed [63:0] sum14;
	assign sum14 = rshr64(acc_q, 14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			step_q <= '0;
			row_q <= '0; col_q <= '0;
			extra_q <= 1'b0; seen_q <= 1'b0;
			close_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (st_q)
				ST_IDLE: if (accept_in) begin
					h_q <= s_tdata;
					close_q <= s_tlast;
					step_q <= '0;
					if (s_tuser && in_grid) begin
						st_q <= ST_MUL;
					end else begin
						if (s_tuser) extra_q <= 1'b1;
						st_q <= s_tlast ? ST_OUT : ST_IDLE;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 6'd1;
					// collect products once they have passed both multiplier registers
					if (step_q >= 6'd2 && step_q <= 6'd11)
						prod_sq_q[arr] <= prod_q[63:0];
					if (step_q == 6'd12) begin
						loc_q[0] <= sat32(rshr64(prod_q[63:0], 1));
						loc_q[1] <= h_q;
						m_q[0] <= r14(one28 - 2*(prod_sq_q[2] + prod_sq_q[3]));
						m_q[1] <= r14(2*(prod_sq_q[4] - prod_sq_q[9]));
						m_q[2] <= r14(2*(prod_sq_q[5] + prod_sq_q[8]));
						m_q[3] <= r14(2*(prod_sq_q[4] + prod_sq_q[9]));
						m_q[4] <= r14(one28 - 2*(prod_sq_q[1] + prod_sq_q[3]));
						m_q[5] <= r14(2*(prod_sq_q[6] - prod_sq_q[7]));
						m_q[6] <= r14(2*(prod_sq_q[5] - prod_sq_q[8]));
						m_q[7] <= r14(2*(prod_sq_q[6] + prod_sq_q[7]));
					end
					if (step_q == 6'd13) begin
						loc_q[2] <= sat32(rshr64(prod_q[63:0], 1));
						m_q[8] <= r14(one28 - 2*(prod_sq_q[1] + prod_sq_q[2]));
					end
					// accumulate row products, one axis each three
					if (step_q >= 6'd16 && step_q <= 6'd24) begin
						if (step_q == 6'd16 || step_q == 6'd19 || step_q == 6'd22)
							acc_q <= prod_q[63:0];
						else acc_q <= acc_q + prod_q[63:0];
					end
					if (step_q == 6'd19) wv_q[0] <= sat32(sum14 + 64'(cx_q));
					if (step_q == 6'd22) wv_q[1] <= sat32(sum14 + 64'(cy_q));
					if (step_q == 6'd25) begin
						wv_q[2] <= sat32(sum14 + 64'(cz_q));
						st_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 3; i++) begin
						if (!seen_q || wv_q[i] < lo_q[i]) lo_q[i] <= wv_q[i];
						if (!seen_q || wv_q[i] > hi_q[i]) hi_q[i] <= wv_q[i];
					end
					seen_q <= 1'b1;
					if (col_q + PW'(1) >= ecols) begin
						col_q <= '0;
						row_q <= row_q + PW'(1);
					end else col_q <= col_q + PW'(1);
					st_q <= close_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					m_tvalid <= 1'b1;
					m_tuser[0] <= (erows == '0) || (ecols == '0);
					m_tuser[1] <= extra_q || (row_q != erows) || (col_q != '0);
					if ((erows == '0) || (ecols == '0))
						m_tdata <= {cz_q, cy_q, cx_q, cz_q, cy_q, cx_q};
					else if (seen_q)
						m_tdata <= {hi_q[2], hi_q[1], hi_q[0], lo_q[2], lo_q[1], lo_q[0]};
					else
						m_tdata <= '0;
					row_q <= '0; col_q <= '0;
					extra_q <= 1'b0; seen_q <= 1'b0;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps

// expected bounds and grid tracking for the rotated height grid
class bounds_board;
	longint centre[3];
	bit [63:0] quat;
	longint spacing;
	int rows_reg, cols_reg;
	int row_pos, col_pos;
	bit extra, seen;
	longint lo[3], hi[3];
	logic [193:0] pending_bounds[$];
	int errors, results, empties, flagged;

	function new();
		centre = '{0, 0, 0};
		quat = 64'h4000_0000_0000_0000;
		spacing = 65536;
		rows_reg = 0;
		cols_reg = 0;
		row_pos = 0;
		col_pos = 0;
		extra = 0;
		seen = 0;
	endfunction

	task report(string msg);
		$display("%0t ERROR: %s", $time, msg);
		errors++;
	endtask

	function longint round_shift(longint a, int s);
		return (a + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function int grid_rows();
		return rows_reg > 256 ? 256 : rows_reg;
	endfunction

	function int grid_cols();
		return cols_reg > 256 ? 256 : cols_reg;
	endfunction

	function void write_reg(logic [2:0] idx, bit [63:0] val);
		case (idx)
			hwb_pkg::REG_CX:   centre[0] = longint'($signed(val[31:0]));
			hwb_pkg::REG_CY:   centre[1] = longint'($signed(val[31:0]));
			hwb_pkg::REG_CZ:   centre[2] = longint'($signed(val[31:0]));
			hwb_pkg::REG_QUAT: quat = val;
			hwb_pkg::REG_CS:   spacing = longint'(val[30:0]);
			hwb_pkg::REG_ROWS: rows_reg = int'(val[8:0]);
			hwb_pkg::REG_COLS: cols_reg = int'(val[8:0]);
			default: ;
		endcase
	endfunction

	// rotate the local grid point and offset by the centre
	function void place_vertex(int row, int col, longint h, output longint v[3]);
		longint qw, qx, qy, qz;
		longint m[3][3];
		longint loc[3];
		longint acc;
		qw = longint'($signed(quat[63:48]));
		qx = longint'($signed(quat[47:32]));
		qy = longint'($signed(quat[31:16]));
		qz = longint'($signed(quat[15:0]));
		m[0][0] = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
		m[0][1] = 2 * (qx * qy - qw * qz);
		m[0][2] = 2 * (qx * qz + qw * qy);
		m[1][0] = 2 * (qx * qy + qw * qz);
		m[1][1] = (64'sd1 <<< 28) - 2 * (qx * qx + qz * qz);
		m[1][2] = 2 * (qy * qz - qw * qx);
		m[2][0] = 2 * (qx * qz - qw * qy);
		m[2][1] = 2 * (qy * qz + qw * qx);
		m[2][2] = (64'sd1 <<< 28) - 2 * (qx * qx + qy * qy);
		foreach (m[i, j]) m[i][j] = round_shift(m[i][j], 14);
		loc[0] = clip32(round_shift((2 * longint'(col) - (grid_cols() - 1)) * spacing, 1));
		loc[1] = h;
		loc[2] = clip32(round_shift((2 * longint'(row) - (grid_rows() - 1)) * spacing, 1));
		for (int i = 0; i < 3; i++) begin
			acc = m[i][0] * loc[0] + m[i][1] * loc[1] + m[i][2] * loc[2];
			v[i] = clip32(round_shift(acc, 14) + centre[i]);
		end
	endfunction

	function void note_item(bit has, bit [31:0] h, bit cl);
		longint v[3];
		longint blo[3], bhi[3];
		bit empty, mism;
		logic [193:0] e;
		if (has) begin
			if (row_pos < grid_rows() && col_pos < grid_cols()) begin
				place_vertex(row_pos, col_pos, longint'($signed(h)), v);
				for (int i = 0; i < 3; i++) begin
					if (!seen || v[i] < lo[i]) lo[i] = v[i];
					if (!seen || v[i] > hi[i]) hi[i] = v[i];
				end
				seen = 1;
				col_pos++;
				if (col_pos >= grid_cols()) begin
					col_pos = 0;
					row_pos++;
				end
			end else begin
				extra = 1;
			end
		end
		if (!cl) return;
		empty = (grid_rows() == 0 || grid_cols() == 0);
		mism = extra || row_pos != grid_rows() || col_pos != 0;
		for (int i = 0; i < 3; i++) begin
			blo[i] = empty ? centre[i] : lo[i];
			bhi[i] = empty ? centre[i] : hi[i];
			e[32*i +: 32] = blo[i][31:0];
			e[32*(i+3) +: 32] = bhi[i][31:0];
		end
		e[193:192] = {mism, empty};
		pending_bounds.push_back(e);
		row_pos = 0;
		col_pos = 0;
		extra = 0;
		seen = 0;
	endfunction

	task check_result(logic [191:0] d, logic [1:0] u);
		string names[6];
		logic [193:0] e;
		names = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};
		if (pending_bounds.size() == 0) begin
			report("bounds word with nothing outstanding");
			return;
		end
		e = pending_bounds.pop_front();
		results++;
		for (int i = 0; i < 6; i++)
			if (d[32*i +: 32] !== e[32*i +: 32])
				report($sformatf("%s got %h want %h", names[i], d[32*i +: 32],
					e[32*i +: 32]));
		if (u[0] !== e[192])
			report($sformatf("empty_grid got %b want %b", u[0], e[192]));
		if (u[1] !== e[193])
			report($sformatf("count_mismatch got %b want %b", u[1], e[193]));
		empties += e[192];
		flagged += e[193];
	endtask
endclass

module tb_top;
	import hwb_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic s_tvalid = 0;
	logic s_tready;
	// height[31:0]
	logic [31:0] s_tdata = '0;
	// has_sample[0]
	logic s_tuser = 0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	// min_x, min_y, min_z, max_x, max_y, max_z from bit 0 upward
	logic [191:0] m_tdata;
	// empty_grid[0], count_mismatch[1]
	logic [1:0] m_tuser;

	bounds_board board = new();
	bit calm = 0;
	bit long_hold_req = 0;
	bit held = 0;
	int items_sent = 0;

	heightfield_world_bounds DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("timeout");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: check each word, stall in bursts
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 0;
			end else if (long_hold_req) begin
				long_hold_req = 0;
				stall_left = 700;
				m_tready <= 0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	task reg_write(logic [2:0] idx, logic [63:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		board.write_reg(idx, val);
	endtask

	task send_word(bit has, bit [31:0] h, bit cl);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= has;
		s_tdata <= h;
		s_tlast <= cl;
		do @(posedge clk); while (!s_tready);
		board.note_item(has, h, cl);
		items_sent++;
	endtask

	// drain results and let any in-flight sample finish
	task settle();
		s_tvalid <= 0;
		while (board.pending_bounds.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function bit [31:0] pick_height();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 131071)) - 32'd65536;
			default: return $urandom;
		endcase
	endfunction

	function bit [63:0] pick_rotation();
		int c[4];
		real n;
		bit [63:0] q;
		case ($urandom_range(0, 5))
			0: return 64'h4000_0000_0000_0000;
			1: return {$urandom, $urandom};
			default: begin
				foreach (c[i]) c[i] = int'($urandom_range(0, 32768)) - 16384;
				n = $sqrt(real'(c[0]) ** 2 + real'(c[1]) ** 2 + real'(c[2]) ** 2
					+ real'(c[3]) ** 2);
				if (n < 1.0) return 64'h4000_0000_0000_0000;
				foreach (c[i]) q[16*(3-i) +: 16] = 16'($rtoi(real'(c[i]) * 16384.0 / n));
				return q;
			end
		endcase
	endfunction

	// n samples with stray noise words, closed on the last sample or by its own word
	task run_grid(int n, bit close_on_last);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0) send_word(0, $urandom, 0);
			send_word(1, pick_height(), close_on_last && k == n - 1);
		end
		if (!(close_on_last && n > 0)) send_word($urandom_range(0, 1) == 0 ? 0 : 0,
			$urandom, 1);
	endtask

	function int pick_size();
		case ($urandom_range(0, 9))
			0: return 256;
			1: return 511;
			2: return $urandom_range(257, 510);
			3: return $urandom_range(7, 16);
			default: return $urandom_range(0, 6);
		endcase
	endfunction

	initial begin
		int total, n;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty grid at reset defaults, with and without stray samples
		send_word(0, 32'h0, 1);
		run_grid(2, 1);
		settle();

		// saturating centre, widest spacing, 2x2 grid at extreme heights
		reg_write(REG_CX, 64'h7FFF_FFFF);
		reg_write(REG_CY, 64'h8000_0000);
		reg_write(REG_CZ, 64'h0001_0000);
		reg_write(REG_QUAT, 64'h4000_0000_0000_0000);
		reg_write(REG_CS, 64'h7FFF_FFFF);
		reg_write(REG_ROWS, 64'd2);
		reg_write(REG_COLS, 64'd2);
		send_word(1, 32'h7FFF_FFFF, 0);
		send_word(1, 32'h8000_0000, 0);
		send_word(0, 32'hFFFF_FFFF, 0);
		send_word(1, 32'h0000_0000, 0);
		send_word(1, 32'hFFFF_FFFF, 1);
		settle();

		// odd quaternion, single cell overrun by extra samples
		reg_write(REG_QUAT, 64'h8000_8000_8000_8000);
		reg_write(REG_CX, 64'h8000_0000);
		reg_write(REG_CS, 64'h0);
		reg_write(REG_ROWS, 64'd1);
		reg_write(REG_COLS, 64'd1);
		send_word(1, 32'h1234_5678, 0);
		send_word(1, 32'h8000_0000, 0);
		send_word(1, 32'h7FFF_FFFF, 1);
		settle();

		// sizes past the limit clamp; short grid
		reg_write(REG_QUAT, 64'h7FFF_7FFF_7FFF_7FFF);
		reg_write(REG_CS, 64'h0001_8000);
		reg_write(REG_ROWS, 64'd511);
		reg_write(REG_COLS, 64'd3);
		run_grid(4, 1);
		settle();
		reg_write(REG_COLS, 64'd0);
		run_grid(1, 0);
		settle();

		// random phases
		while (items_sent < 1950) begin
			if (items_sent > 1650) calm = 1;
			if ($urandom_range(0, 1)) reg_write(REG_CX, {32'h0, pick_height()});
			if ($urandom_range(0, 1)) reg_write(REG_CY, {32'h0, pick_height()});
			if ($urandom_range(0, 1)) reg_write(REG_CZ, {32'h0, pick_height()});
			if ($urandom_range(0, 1)) reg_write(REG_QUAT, pick_rotation());
			if ($urandom_range(0, 2) == 0)
				reg_write(REG_CS, $urandom_range(0, 3) == 0 ? {32'h0, $urandom}
					: 64'($urandom_range(0, 262144)));
			if ($urandom_range(0, 1)) reg_write(REG_ROWS, 64'(pick_size()));
			if ($urandom_range(0, 1)) reg_write(REG_COLS, 64'(pick_size()));
			total = board.grid_rows() * board.grid_cols();
			repeat ($urandom_range(1, 4)) begin
				if (items_sent < 1950) begin
					if (total == 0) n = $urandom_range(0, 3);
					else case ($urandom_range(0, 9))
						0, 1: n = total > 1
							? $urandom_range(1, total > 300 ? 20 : total - 1) : 1;
						2: n = total <= 300 ? total + $urandom_range(1, 3) : 1;
						default: n = total <= 300 ? total : $urandom_range(1, 20);
					endcase
					run_grid(n, $urandom_range(0, 1));
				end
			end
			settle();

			// once: hold the result side while single-cell grids keep coming
			if (!held && items_sent > 800) begin
				reg_write(REG_ROWS, 64'd1);
				reg_write(REG_COLS, 64'd1);
				long_hold_req = 1;
				repeat (8) run_grid(1, 1);
				settle();
				held = 1;
			end
		end
		settle();

		$display("%0d words sent, %0d bounds results checked", items_sent, board.results);
		$display("%0d empty grids, %0d with count flag", board.empties, board.flagged);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
